/* src/lfpp_pkg.sv */
package lfpp_pkg;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_DATA    = 6'b000100,
    PH_SUM     = 6'b001000,
    PH_TAIL    = 6'b010000,
    PH_DELIVER = 6'b100000
  } lfpp_phase_e;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_HEADER   = 2'd0,
    REG_TAIL     = 2'd1,
    REG_CHECKSUM = 2'd2,
    REG_DELIVERY = 2'd3
  } lfpp_reg_e;

  localparam logic [7:0] HEADER_RESET = 8'hFF;
  localparam logic [7:0] TAIL_RESET   = 8'hFE;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] tail_value;
    logic       checksum_enable;
    logic       delivery_enable;
  } lfpp_cfg_t;

endpackage

/* src/lfpp_if.sv */
interface lfpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfpp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [4:0] payload_index;
  logic [5:0] payload_length;
  logic       last;

  modport source (output valid, output payload_byte, output payload_index,
                  output payload_length, output last, input ready);
  modport sink   (input valid, input payload_byte, input payload_index,
                  input payload_length, input last, output ready);
endinterface

/* src/lfpp_cell.sv */
module lfpp_cell (
  input  logic       clk_i,
  input  logic       shift_en_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

/* src/lfpp_cfg.sv */
module lfpp_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output lfpp_pkg::lfpp_cfg_t   cfg_o
);

  lfpp_pkg::lfpp_cfg_t cfg_q;
  lfpp_pkg::lfpp_reg_e reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lfpp_pkg::lfpp_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value    <= lfpp_pkg::HEADER_RESET;
      cfg_q.tail_value      <= lfpp_pkg::TAIL_RESET;
      cfg_q.checksum_enable <= 1'b0;
      cfg_q.delivery_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        lfpp_pkg::REG_HEADER:   cfg_q.header_value    <= pwdata[7:0];
        lfpp_pkg::REG_TAIL:     cfg_q.tail_value      <= pwdata[7:0];
        lfpp_pkg::REG_CHECKSUM: cfg_q.checksum_enable <= pwdata[0];
        lfpp_pkg::REG_DELIVERY: cfg_q.delivery_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      lfpp_pkg::REG_HEADER:   prdata = {24'd0, cfg_q.header_value};
      lfpp_pkg::REG_TAIL:     prdata = {24'd0, cfg_q.tail_value};
      lfpp_pkg::REG_CHECKSUM: prdata = {31'd0, cfg_q.checksum_enable};
      lfpp_pkg::REG_DELIVERY: prdata = {31'd0, cfg_q.delivery_enable};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/length_framed_packet_parser_core.sv */
// Frame parser for a byte stream: header, length (1..PAYLOAD_DEPTH), payload, optional
// 8-bit sum byte, tail. Payload bytes shift into a chain of PAYLOAD_DEPTH byte cells;
// once a matching tail is taken with delivery enabled, the chain shifts towards its far
// end PAYLOAD_DEPTH times (each shift waits while the output is stalled), the first
// PAYLOAD_DEPTH minus length shifts aligning the frame and the remaining length of them
// handing one payload beat each to the output register. No byte is taken while that
// drain runs.
module length_framed_packet_parser_core #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lfpp_rx_if.sink            rx_i,
  lfpp_res_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  lfpp_pkg::lfpp_cfg_t   cfg;
  lfpp_pkg::lfpp_phase_e phase_q, phase_d;
  logic [CW-1:0]         exp_len_q, exp_len_d;
  logic [CW-1:0]         rcv_cnt_q, rcv_cnt_d;
  logic [CW-1:0]         skip_q, skip_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [7:0]            sum_q, sum_d;
  logic [CW-1:0]         rcv_cnt_inc;
  logic [7:0]            rx_b;
  logic                  in_acc, slot_free, dlv_shift, emit, emit_last, shift_en;
  logic [7:0]            cell_out [PAYLOAD_DEPTH];

  logic                  out_valid_q;
  logic [7:0]            out_byte_q;
  logic [4:0]            out_idx_q;
  logic [5:0]            out_len_q;
  logic                  out_last_q;

  lfpp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rx_b        = rx_i.rx_byte;
  assign rx_i.ready  = (phase_q != lfpp_pkg::PH_DELIVER);
  assign in_acc      = rx_i.valid && rx_i.ready;
  assign slot_free   = !out_valid_q || res_o.ready;
  assign dlv_shift   = (phase_q == lfpp_pkg::PH_DELIVER) && slot_free;
  assign emit        = dlv_shift && (skip_q == '0);
  assign emit_last   = emit && (idx_q == CW'(exp_len_q - CW'(1)));
  assign rcv_cnt_inc = CW'(rcv_cnt_q + CW'(1));
  assign shift_en    = (in_acc && (phase_q == lfpp_pkg::PH_DATA)) || dlv_shift;

  // Byte cell chain: payload enters at cell 0 and drains from the far end
  for (genvar i = 0; i < PAYLOAD_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      lfpp_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (shift_en),
        .data_i     (rx_b),
        .data_o     (cell_out[i])
      );
    end else begin : g_body
      lfpp_cell u_cell (
        .clk_i      (clk_i),
        .shift_en_i (shift_en),
        .data_i     (cell_out[i-1]),
        .data_o     (cell_out[i])
      );
    end
  end

  always_comb begin
    phase_d   = phase_q;
    exp_len_d = exp_len_q;
    rcv_cnt_d = rcv_cnt_q;
    skip_d    = skip_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    unique case (phase_q)
      lfpp_pkg::PH_IDLE: begin
        if (in_acc && (rx_b == cfg.header_value)) begin
          phase_d = lfpp_pkg::PH_LENGTH;
        end
      end
      lfpp_pkg::PH_LENGTH: begin
        if (in_acc) begin
          // Drop empty or oversized frames
          if ((rx_b == 8'd0) || ({1'b0, rx_b} > 9'(PAYLOAD_DEPTH))) begin
            phase_d = lfpp_pkg::PH_IDLE;
          end else begin
            exp_len_d = CW'(rx_b);
            rcv_cnt_d = '0;
            sum_d     = 8'(cfg.header_value + rx_b);
            phase_d   = lfpp_pkg::PH_DATA;
          end
        end
      end
      lfpp_pkg::PH_DATA: begin
        if (in_acc) begin
          rcv_cnt_d = rcv_cnt_inc;
          sum_d     = 8'(sum_q + rx_b);
          if (rcv_cnt_inc >= exp_len_q) begin
            phase_d = cfg.checksum_enable ? lfpp_pkg::PH_SUM : lfpp_pkg::PH_TAIL;
          end
        end
      end
      lfpp_pkg::PH_SUM: begin
        if (in_acc) begin
          phase_d = (rx_b == sum_q) ? lfpp_pkg::PH_TAIL : lfpp_pkg::PH_IDLE;
        end
      end
      lfpp_pkg::PH_TAIL: begin
        if (in_acc) begin
          if ((rx_b == cfg.tail_value) && cfg.delivery_enable) begin
            skip_d  = CW'(CW'(PAYLOAD_DEPTH) - exp_len_q);
            idx_d   = '0;
            phase_d = lfpp_pkg::PH_DELIVER;
          end else begin
            phase_d = lfpp_pkg::PH_IDLE;
          end
        end
      end
      lfpp_pkg::PH_DELIVER: begin
        if (dlv_shift) begin
          // Align the first payload byte to the far cell, then emit a beat per shift
          if (skip_q != '0) begin
            skip_d = CW'(skip_q - CW'(1));
          end else begin
            idx_d = CW'(idx_q + CW'(1));
            if (emit_last) begin
              phase_d = lfpp_pkg::PH_IDLE;
            end
          end
        end
      end
      default: phase_d = lfpp_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lfpp_pkg::PH_IDLE;
      exp_len_q   <= '0;
      rcv_cnt_q   <= '0;
      skip_q      <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      rcv_cnt_q <= rcv_cnt_d;
      skip_q    <= skip_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cell_out[PAYLOAD_DEPTH-1];
      out_idx_q  <= 5'(idx_q);
      out_len_q  <= 6'(exp_len_q);
      out_last_q <= emit_last;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.payload_byte   = out_byte_q;
  assign res_o.payload_index  = out_idx_q;
  assign res_o.payload_length = out_len_q;
  assign res_o.last           = out_last_q;

endmodule

/* tb/lfpp_frame_checker.sv */
module lfpp_frame_checker #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfpp_rx_if          rx_i,
  lfpp_res_if         res_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          error_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic [5:0] payload_length;
    logic       last;
  } payload_beat_t;

  payload_beat_t         pending_beats_q[$];
  lfpp_pkg::lfpp_cfg_t   cfg;
  lfpp_pkg::lfpp_phase_e phase;
  logic [5:0]            frame_length;
  logic [5:0]            bytes_seen;
  logic [7:0]            frame_sum;
  logic [7:0]            payload_mem [PAYLOAD_DEPTH];
  int                    mismatch_count;

  task automatic parse_rx_byte(input logic [7:0] b);
    payload_beat_t beat;
    case (phase)
      lfpp_pkg::PH_IDLE: begin
        if (b == cfg.header_value) phase = lfpp_pkg::PH_LENGTH;
      end
      lfpp_pkg::PH_LENGTH: begin
        // a rejected length byte is dropped, never taken as a new header
        if (b == 8'd0 || b > PAYLOAD_DEPTH) begin
          phase = lfpp_pkg::PH_IDLE;
        end else begin
          frame_length = b[5:0];
          bytes_seen   = '0;
          frame_sum    = cfg.header_value + b;
          phase        = lfpp_pkg::PH_DATA;
        end
      end
      lfpp_pkg::PH_DATA: begin
        payload_mem[IW'(bytes_seen)] = b;
        bytes_seen++;
        frame_sum += b;
        // checksum mode is sampled on the last payload byte
        if (bytes_seen >= frame_length) begin
          phase = cfg.checksum_enable ? lfpp_pkg::PH_SUM : lfpp_pkg::PH_TAIL;
        end
      end
      lfpp_pkg::PH_SUM: begin
        phase = (b == frame_sum) ? lfpp_pkg::PH_TAIL : lfpp_pkg::PH_IDLE;
      end
      lfpp_pkg::PH_TAIL: begin
        if (b == cfg.tail_value && cfg.delivery_enable) begin
          for (int k = 0; k < frame_length; k++) begin
            beat.payload_byte   = payload_mem[k];
            beat.payload_index  = 5'(k);
            beat.payload_length = frame_length;
            beat.last           = (k + 1 == frame_length);
            pending_beats_q.push_back(beat);
          end
        end
        phase = lfpp_pkg::PH_IDLE;
      end
      default: begin
        phase = lfpp_pkg::PH_IDLE;
      end
    endcase
  endtask

  task automatic check_payload_beat();
    payload_beat_t want;
    if (pending_beats_q.size() == 0) begin
      $error("payload beat with none pending: byte %0h index %0d",
             res_i.payload_byte, res_i.payload_index);
      mismatch_count++;
    end else begin
      want = pending_beats_q.pop_front();
      if (res_i.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", want.payload_byte, res_i.payload_byte);
        mismatch_count++;
      end
      if (res_i.payload_index !== want.payload_index) begin
        $error("payload_index: expected %0d, actual %0d", want.payload_index,
               res_i.payload_index);
        mismatch_count++;
      end
      if (res_i.payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, actual %0d", want.payload_length,
               res_i.payload_length);
        mismatch_count++;
      end
      if (res_i.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, res_i.last);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg          = '{lfpp_pkg::HEADER_RESET, lfpp_pkg::TAIL_RESET, 1'b0, 1'b0};
      phase        = lfpp_pkg::PH_IDLE;
      frame_length = '0;
      bytes_seen   = '0;
      frame_sum    = '0;
      pending_beats_q.delete();
      outstanding_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (lfpp_pkg::lfpp_reg_e'(paddr[3:2]))
          lfpp_pkg::REG_HEADER:   cfg.header_value    = pwdata[7:0];
          lfpp_pkg::REG_TAIL:     cfg.tail_value      = pwdata[7:0];
          lfpp_pkg::REG_CHECKSUM: cfg.checksum_enable = pwdata[0];
          lfpp_pkg::REG_DELIVERY: cfg.delivery_enable = pwdata[0];
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready) parse_rx_byte(rx_i.rx_byte);
      if (res_i.valid && res_i.ready) check_payload_beat();
      outstanding_o <= pending_beats_q.size();
      error_count_o <= mismatch_count;
    end
  end

endmodule

/* tb/tb_length_framed_packet_parser_core.sv */
module tb_length_framed_packet_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL} frame_kind_e;
  typedef enum {CUT_NONE, CUT_AFTER_HEADER, CUT_IN_PAYLOAD} frame_cut_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  error_count;
  int                  outstanding;
  int                  cycle_count = 0;
  bit                  idle_on;
  lfpp_pkg::lfpp_cfg_t cfg_now;

  lfpp_rx_if  rx ();
  lfpp_res_if res ();

  length_framed_packet_parser_core #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lfpp_frame_checker #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx),
    .res_i         (res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall bursts while idling is on
  initial begin
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  task automatic send_rx_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
  endtask

  // hold off until every pending payload beat is out and the drain has settled
  task automatic wait_drained();
    rx.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (PAYLOAD_DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input lfpp_pkg::lfpp_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // junk in the unused upper bits must be ignored
  task automatic write_config(input logic [7:0] hdr, input logic [7:0] tl,
                              input logic sum_en, input logic deliv);
    wait_drained();
    write_reg(lfpp_pkg::REG_HEADER,   {24'($urandom), hdr});
    write_reg(lfpp_pkg::REG_TAIL,     {24'($urandom), tl});
    write_reg(lfpp_pkg::REG_CHECKSUM, {31'($urandom), sum_en});
    write_reg(lfpp_pkg::REG_DELIVERY, {31'($urandom), deliv});
    cfg_now = '{hdr, tl, sum_en, deliv};
  endtask

  task automatic write_random_config();
    write_config(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 3) != 0);
  endtask

  task automatic send_frame(input logic [7:0] payload[$], input frame_kind_e kind,
                            input frame_cut_e cut);
    logic [7:0] sum;
    int         cut_pos;
    cut_pos = (payload.size() > 1) ? $urandom_range(1, payload.size() - 1) : 0;
    send_rx_byte(cfg_now.header_value);
    if (cut == CUT_AFTER_HEADER) write_random_config();
    send_rx_byte(8'(payload.size()));
    sum = cfg_now.header_value + 8'(payload.size());
    foreach (payload[i]) begin
      // reconfigure before a later payload byte, at the latest the last, so the new sum mode applies
      if (cut == CUT_IN_PAYLOAD && i == cut_pos) write_random_config();
      send_rx_byte(payload[i]);
      sum += payload[i];
    end
    if (cfg_now.checksum_enable) begin
      if (kind == FRAME_BAD_SUM) begin
        send_rx_byte(sum ^ 8'($urandom_range(1, 255)));
        return;
      end
      send_rx_byte(sum);
    end
    if (kind == FRAME_BAD_TAIL) send_rx_byte(cfg_now.tail_value ^ 8'($urandom_range(1, 255)));
    else send_rx_byte(cfg_now.tail_value);
  endtask

  task automatic run_random_frames(input int byte_budget, input bit open_full);
    logic [7:0] payload[$];
    logic [7:0] b;
    int         sent;
    int         pick;
    int         len;
    frame_kind_e kind;
    frame_cut_e  cut;
    sent = 0;
    while (sent < byte_budget) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // stray byte between frames, kept off the header value
        b = 8'($urandom);
        if (b == cfg_now.header_value) b = ~b;
        send_rx_byte(b);
      end else if (pick == 1) begin
        send_rx_byte(cfg_now.header_value);
        if ($urandom_range(0, 2) == 0) send_rx_byte(8'd0);
        else send_rx_byte(8'($urandom_range(PAYLOAD_DEPTH + 1, 255)));
        sent += 2;
      end else begin
        case ($urandom_range(0, 7))
          0:       len = PAYLOAD_DEPTH;
          1:       len = $urandom_range(9, PAYLOAD_DEPTH);
          default: len = $urandom_range(1, 8);
        endcase
        if (open_full && sent == 0) len = PAYLOAD_DEPTH;
        payload.delete();
        repeat (len) payload.push_back(8'($urandom));
        kind = (pick == 2) ? FRAME_BAD_SUM : (pick == 3) ? FRAME_BAD_TAIL : FRAME_GOOD;
        case ($urandom_range(0, 11))
          0:       cut = CUT_AFTER_HEADER;
          1:       cut = CUT_IN_PAYLOAD;
          default: cut = CUT_NONE;
        endcase
        send_frame(payload, kind, cut);
        sent += len + 3;
      end
    end
  endtask

  initial begin
    logic [7:0] bytes_q[$];
    rst_ni     <= 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= 4'h0;
    pwdata     <= 32'h0;
    idle_on    = 1'b1;
    cfg_now    = '{lfpp_pkg::HEADER_RESET, lfpp_pkg::TAIL_RESET, 1'b0, 1'b0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // delivery still off after reset: a good frame vanishes
    bytes_q = {8'hA5};
    send_frame(bytes_q, FRAME_GOOD, CUT_NONE);
    write_config(lfpp_pkg::HEADER_RESET, lfpp_pkg::TAIL_RESET, 1'b0, 1'b1);
    bytes_q = {8'h00};
    send_frame(bytes_q, FRAME_GOOD, CUT_NONE);
    // zero length, then an oversize length equal to the header that must not restart
    send_rx_byte(lfpp_pkg::HEADER_RESET);
    send_rx_byte(8'h00);
    send_rx_byte(lfpp_pkg::HEADER_RESET);
    send_rx_byte(8'hFF);
    send_rx_byte(8'h01);
    bytes_q = {8'h12, 8'h34};
    send_frame(bytes_q, FRAME_BAD_TAIL, CUT_NONE);
    write_config(lfpp_pkg::HEADER_RESET, lfpp_pkg::TAIL_RESET, 1'b1, 1'b1);
    bytes_q = {8'hFF, 8'h80};
    send_frame(bytes_q, FRAME_GOOD, CUT_NONE);
    bytes_q = {8'h7F};
    send_frame(bytes_q, FRAME_BAD_SUM, CUT_NONE);

    write_config(8'h00, 8'hFF, 1'b1, 1'b1);
    run_random_frames(20, 1'b1);
    write_config(8'hFF, 8'h00, 1'b0, 1'b1);
    run_random_frames(20, 1'b1);
    write_config(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
    run_random_frames(10, 1'b0);
    // last stretch runs flat out on both sides
    idle_on = 1'b0;
    write_config(8'($urandom), 8'($urandom), 1'b1, 1'b1);
    run_random_frames(20, 1'b0);

    wait_drained();
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
